>>> hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache core.
package lkvc_pkg;

   localparam int KEY_W               = 32;
   localparam int DATA_W              = 32;
   localparam int CAP_W               = 5;
   localparam int MAX_ENTRIES_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // Request operation codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
   localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

   // One entry of the recency chain
   typedef struct packed {
      logic                     valid;
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] value;
   } entry_type;

endpackage

>>> hdl/lkvc_cell.sv
// One position of the recency chain: holds an entry, compares its key, takes its neighbor's entry.
module lkvc_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 move,
   input  lkvc_pkg::entry_type                  shift_in,
   input  logic signed [lkvc_pkg::KEY_W-1:0]    cmp_key,
   output lkvc_pkg::entry_type                  entry_out,
   output logic                                 match
);
   import lkvc_pkg::*;

   logic                     valid_ff;
   logic signed [KEY_W-1:0]  key_ff;
   logic signed [DATA_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (move) begin
         valid_ff <= shift_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         key_ff   <= shift_in.key;
         value_ff <= shift_in.value;
      end
   end

   assign match     = valid_ff && (key_ff == cmp_key);
   assign entry_out = '{valid: valid_ff, key: key_ff, value: value_ff};

endmodule

>>> hdl/lru_key_value_cache_core.sv
// Top level of the LRU key/value cache: request handling, recency chain and response register.
//
//   channel | direction | handshake                        | payload
//   --------+-----------+----------------------------------+------------------------------
//   req     | in        | req_valid / req_ready            | req_cmd, req_key, req_data_in
//   rsp     | out       | rsp_valid / rsp_ready            | rsp_hit, rsp_data_out
//   csr     | in        | csr_write_enable (no wait)       | csr_write_data (capacity)
//
// For each request, every cell compares the incoming key against its own
// entry as the request is accepted, then in the update state the chain
// shifts and the response register loads. Chain position is recency rank:
// cell 0 holds the most recent entry, the last valid cell the least recent.
// A stalled response holds the update cycle until the response register
// frees up; req_ready stays low meanwhile. Reset is synchronous: all cells
// invalid, entry count zero, capacity back to its reset value.
module lru_key_value_cache_core #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [lkvc_pkg::KEY_W-1:0]    req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0]   req_data_in,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::DATA_W-1:0]   rsp_data_out,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]           csr_write_data
);
   import lkvc_pkg::*;

   localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type                state_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;

   logic                     cmd_ff;
   logic signed [KEY_W-1:0]  key_ff;
   logic signed [DATA_W-1:0] data_ff;
   logic [MAX_ENTRIES-1:0]   match_ff;
   logic                     evict_ff;
   logic [POS_W-1:0]         miss_pos_ff;

   logic [CAP_W-1:0]         capacity_ff;
   logic [CNT_W-1:0]         count_ff;

   entry_type                cell_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]   cell_match;
   logic [MAX_ENTRIES-1:0]   cell_move;
   entry_type                new_entry;

   logic                     accept;
   logic                     out_free;
   logic                     finish;
   logic                     upd;
   logic                     hit;
   logic [POS_W-1:0]         hit_pos;
   logic signed [DATA_W-1:0] hit_value;
   logic [POS_W-1:0]         move_limit;
   logic [CMP_W-1:0]         cap_ext;
   logic [CMP_W-1:0]         eff_cap;
   logic                     evict_in;
   logic [POS_W-1:0]         miss_pos_in;
   logic                     rsp_hit_in;
   logic signed [DATA_W-1:0] rsp_data_in;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign finish       = (state_ff == ST_UPDATE) && out_free;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_data_out = rsp_data_ff;

   // Effective capacity: zero counts as one, saturate at the chain length
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      evict_in = (CMP_W'(count_ff) >= eff_cap);
      // On a miss with eviction the last valid cell drops off the chain end;
      // otherwise the first free cell takes the shifted-out entry.
      if (evict_in) begin
         miss_pos_in = POS_W'(count_ff - CNT_W'(1));
      end else begin
         miss_pos_in = POS_W'(count_ff);
      end
   end

   // Locate the hit; keys are distinct among valid cells, so at most one matches
   always_comb begin
      hit_pos   = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (match_ff[i]) begin
            hit_pos   = hit_pos | POS_W'(i);
            hit_value = hit_value | cell_entry[i].value;
         end
      end
      hit = |match_ff;
   end

   // A get miss leaves the chain untouched; everything else moves an entry to the front
   assign upd        = finish && (hit || (cmd_ff == CMD_PUT));
   assign move_limit = hit ? hit_pos : miss_pos_ff;

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.key   = key_ff;
      new_entry.value = (cmd_ff == CMD_PUT) ? data_ff : hit_value;
   end

   always_comb begin
      rsp_hit_in = hit;
      if (cmd_ff == CMD_PUT) begin
         rsp_data_in = PUT_VALUE;
      end else if (hit) begin
         rsp_data_in = hit_value;
      end else begin
         rsp_data_in = MISS_VALUE;
      end
   end

   // Recency chain: cells up to the move limit take their neighbor's entry
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      assign cell_move[g] = upd && (POS_W'(g) <= move_limit);

      if (g == 0) begin : g_head
         lkvc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .move      (cell_move[g]),
            .shift_in  (new_entry),
            .cmp_key   (req_key),
            .entry_out (cell_entry[g]),
            .match     (cell_match[g])
         );
      end else begin : g_body
         lkvc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .move      (cell_move[g]),
            .shift_in  (cell_entry[g-1]),
            .cmp_key   (req_key),
            .entry_out (cell_entry[g]),
            .match     (cell_match[g])
         );
      end
   end

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            rsp_hit_ff   <= rsp_hit_in;
            rsp_data_ff  <= rsp_data_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Capture the request along with the compare results of every cell
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_cmd;
         key_ff      <= req_key;
         data_ff     <= req_data_in;
         match_ff    <= cell_match;
         evict_ff    <= evict_in;
         miss_pos_ff <= miss_pos_in;
      end
   end

   // Entry count grows only on an insert without eviction
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (upd && !hit && !evict_ff) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

endmodule

>>> hdl/lkvc_checker.sv
// Port-level checks for the LRU key/value cache core, bound to the top level.
module lkvc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_hit,
   input logic signed [lkvc_pkg::DATA_W-1:0]   rsp_data_out
);
   import lkvc_pkg::*;

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_data_out))
      else $error("response changed while stalled");

   // One request in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A fresh response follows an accepted request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready) || $past(!req_ready))
      else $error("response without a request");

   // A miss returns either the get miss value or the put value
   a_miss_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_data_out == MISS_VALUE) || (rsp_data_out == PUT_VALUE))
      else $error("miss response carries stored data");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_hit      (rsp_hit),
   .rsp_data_out (rsp_data_out)
);

>>> tb/lru_cache_checker.sv
// Channel monitor for the LRU key/value cache core: recency predictor and response comparison.
module lru_cache_checker #(
   parameter int SLOTS = lkvc_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_cmd,
   input  logic signed [lkvc_pkg::KEY_W-1:0]  req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0] req_data_in,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_hit,
   input  logic signed [lkvc_pkg::DATA_W-1:0] rsp_data_out,
   input  logic                               csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]         csr_write_data,
   output int                                 fail_count,
   output int                                 pending_answers,
   output int                                 hit_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lkvc_pkg::*;

   typedef struct {
      int unsigned       seq;
      logic              hit;
      logic [DATA_W-1:0] data;
   } cache_answer_type;

   cache_answer_type  answer_q [$];

   logic              slot_valid [SLOTS];
   logic [KEY_W-1:0]  slot_key   [SLOTS];
   logic [DATA_W-1:0] slot_value [SLOTS];
   int unsigned       slot_age   [SLOTS];
   int unsigned       slot_count;
   logic [CAP_W-1:0]  capacity;
   int unsigned       request_seq;
   int                mismatch_total = 0;
   int                hits_total = 0;

   task automatic report_mismatch(input string what);
      mismatch_total++;
      $display("[%0t] MISMATCH %s", $time, what);
   endtask

   function automatic int find_slot(input logic [KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
   endfunction

   // Age every entry that was newer than slot s, then make s the newest.
   function automatic void make_newest(input int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
   endfunction

   function automatic void drop_oldest();
      int          sel;
      int unsigned oldest;
      sel = -1;
      oldest = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid[i] && (sel < 0 || slot_age[i] > oldest)) begin
            sel = i;
            oldest = slot_age[i];
         end
      end
      if (sel >= 0) begin
         slot_valid[sel] = 1'b0;
         slot_age[sel] = 0;
         if (slot_count > 0) slot_count--;
      end
   endfunction

   // Evict one entry when at or over the effective capacity, then fill the lowest free slot.
   function automatic void insert_entry(input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] v);
      int unsigned limit;
      int          free_slot;
      limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
      free_slot = -1;
      if (slot_count >= limit || slot_count >= SLOTS) drop_oldest();
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_valid[i]) begin
            free_slot = i;
            break;
         end
      end
      if (free_slot < 0) return;
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i]) slot_age[i]++;
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = k;
      slot_value[free_slot] = v;
      slot_age[free_slot] = 0;
      slot_count++;
   endfunction

   function automatic cache_answer_type cache_access(input logic op, input logic [KEY_W-1:0] k,
                                                     input logic [DATA_W-1:0] v);
      cache_answer_type a;
      int               s;
      s = find_slot(k);
      a.seq = request_seq;
      a.hit = (s >= 0);
      if (op == CMD_GET) begin
         if (s >= 0) begin
            a.data = slot_value[s];
            make_newest(s);
         end else begin
            a.data = MISS_VALUE;
         end
      end else begin
         a.data = PUT_VALUE;
         if (s >= 0) begin
            slot_value[s] = v;
            make_newest(s);
         end else begin
            insert_entry(k, v);
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin : watch
      cache_answer_type want;
      if (reset) begin
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_age[i] = 0;
         end
         slot_count = 0;
         capacity = CAPACITY_RESET;
         request_seq = 0;
         answer_q.delete();
      end else begin
         // Retire the oldest answer first: a request taken at this edge cannot answer yet.
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding: hit %b data %0d",
                                         rsp_hit, rsp_data_out));
            end else begin
               want = answer_q.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("request %0d: hit %b, predicted %b",
                                            want.seq, rsp_hit, want.hit));
               if (rsp_data_out !== want.data)
                  report_mismatch($sformatf("request %0d: data_out %h, predicted %h",
                                            want.seq, rsp_data_out, want.data));
            end
            if (rsp_hit === 1'b1) hits_total++;
         end
         if (csr_write_enable) capacity = csr_write_data;
         if (req_valid && req_ready) begin
            answer_q.push_back(cache_access(req_cmd, req_key, req_data_in));
            request_seq++;
         end
      end
      fail_count <= mismatch_total;
      hit_count <= hits_total;
      pending_answers <= answer_q.size();
   end

endmodule

>>> tb/tb_lru_key_value_cache_core.sv
// Testbench top for the LRU key/value cache core: request and response traffic and verdict.
module tb_lru_key_value_cache_core;
   timeunit 1ns;
   timeprecision 1ps;
   import lkvc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;     // response hold-off that backs the core up
   localparam int PHASE_ITEMS = 128;
   localparam int STALL_PHASE = 5;
   localparam int HOT_KEYS    = 24;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_cmd = CMD_GET;
   logic signed [KEY_W-1:0]  req_key = '0;
   logic signed [DATA_W-1:0] req_data_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_hit;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic                     csr_write_enable = 1'b0;
   logic [CAP_W-1:0]         csr_write_data = CAPACITY_RESET;

   int                       fail_count;
   int                       pending_answers;
   int                       hit_count;
   int unsigned              cycle_count = 0;
   int unsigned              get_count = 0;
   int unsigned              put_count = 0;
   int unsigned              setting_count = 0;

   // Traffic shaping, shared between the request and response processes.
   bit                       req_burst = 1'b0;
   bit                       rsp_burst = 1'b0;
   bit                       long_hold_pending = 1'b0;
   logic [KEY_W-1:0]         hot_keys [HOT_KEYS];
   int unsigned              hot_span = 4;

   always #1 clock = ~clock;

   lru_key_value_cache_core #(
      .MAX_ENTRIES(MAX_ENTRIES_DEFAULT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_data_out    (rsp_data_out),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   lru_cache_checker #(
      .SLOTS(MAX_ENTRIES_DEFAULT)
   ) cache_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_data_out    (rsp_data_out),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending_answers (pending_answers),
      .hit_count       (hit_count)
   );

   // Count cycles; the watchdog below gives up once the limit is reached.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending_answers);
      $display("== FAIL ==");
      $finish;
   end

   // Idle cycles ahead of one request or one response; none at all during a burst.
   function automatic int unsigned draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 17);
   endfunction

   // Offer one request and return at the edge that takes it. Valid stays high
   // afterwards; drop it only when the next gap is nonzero, so a back-to-back
   // request never sees valid lowered and raised in the same step.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                               input logic [DATA_W-1:0] v);
      int unsigned gap;
      gap = draw_gap(req_burst);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= op;
      req_key     <= k;
      req_data_in <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == CMD_GET) get_count++;
      else put_count++;
   endtask

   // Hold the request side quiet until every outstanding response is back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write the capacity register; call only while the core is idle.
   task automatic set_capacity(input logic [CAP_W-1:0] c);
      csr_write_enable <= 1'b1;
      csr_write_data   <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   // Mostly reuse a small key set sized just above capacity, so hits, updates
   // and evictions all happen; now and then throw in a fresh random key.
   task automatic random_request();
      logic [KEY_W-1:0] k;
      logic             op;
      if ($urandom_range(0, 99) < 85) k = hot_keys[$urandom_range(0, hot_span - 1)];
      else k = $urandom;
      op = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
      send_request(op, k, $urandom);
   endtask

   // Response side: wait a drawn number of cycles before each response, or a
   // long hold-off when the request side asks for one.
   initial begin : rsp_side
      int unsigned hold;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else begin
            hold = draw_gap(rsp_burst);
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0] plan [8];
      int unsigned      eff;
      plan = '{5'd16, 5'd31, 5'd4, 5'd1, 5'd0, 5'd16, 5'd9, 5'd2};
      plan[6] = CAP_W'($urandom_range(3, 15));
      foreach (hot_keys[i]) hot_keys[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_capacity(CAPACITY_RESET);

      // Extremes of key and value, get on an empty store, hits, a one-bit
      // near miss, an overwrite, and a get whose data_in must be ignored.
      send_request(CMD_GET, 32'h0000_0000, $urandom);
      send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'h7FFF_FFFE, 32'h0000_0000);
      send_request(CMD_PUT, 32'h8000_0000, 32'h1234_5678);
      send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);

      // Lower capacity below the current fill: each new key evicts one entry.
      wait_idle();
      set_capacity(5'd2);
      send_request(CMD_PUT, 32'h0000_0011, 32'h0000_0A11);
      send_request(CMD_PUT, 32'h0000_0022, 32'h0000_0A22);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0011, 32'h0000_0000);

      // Capacity zero acts as one.
      wait_idle();
      set_capacity(5'd0);
      send_request(CMD_PUT, 32'h0000_0033, 32'h0000_0A33);
      send_request(CMD_GET, 32'h0000_0033, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0011, 32'h0000_0000);

      // Capacity above the slot count saturates.
      wait_idle();
      set_capacity(5'd31);
      send_request(CMD_PUT, 32'h0000_0044, 32'h0000_0A44);
      send_request(CMD_GET, 32'h0000_0033, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0044, 32'h0000_0000);

      // Random phases, one capacity setting each, drained in between.
      foreach (plan[p]) begin
         wait_idle();
         set_capacity(plan[p]);
         eff = (plan[p] == 0) ? 1 :
               ((plan[p] > MAX_ENTRIES_DEFAULT) ? MAX_ENTRIES_DEFAULT : plan[p]);
         hot_span = eff + $urandom_range(1, 6);
         if (hot_span > HOT_KEYS) hot_span = HOT_KEYS;
         if (p == STALL_PHASE) begin
            // Stream requests back to back into a stalled response side.
            req_burst = 1'b1;
            rsp_burst = 1'b0;
            long_hold_pending = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 32 == 0 && !(p == STALL_PHASE && n < 64)) begin
               req_burst = ($urandom_range(0, 3) == 0);
               rsp_burst = ($urandom_range(0, 3) == 0);
            end
            random_request();
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);

      $display("Covered %0d gets and %0d puts (%0d hits) across %0d capacity writes",
               get_count, put_count, hit_count, setting_count);
      $display("Capacities 0, 1, 2, 4, 16, 31 and one random, with a long response stall");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> lru_key_value_cache_core.f
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache_core.sv
hdl/lkvc_checker.sv
tb/lru_cache_checker.sv
tb/tb_lru_key_value_cache_core.sv
